[src/lmcr_pkg.sv]
// Shared types, font and logo tables for the LED matrix counter renderer.
package lmcr_pkg;

  localparam int ColumnsDefault = 32;

  // Payload widths fixed by the item format.
  localparam int ColW   = 5;
  localparam int RowW   = 3;
  localparam int ShiftW = 6;
  localparam int CountW = 14;
  localparam int ChanW  = 8;
  localparam int IdxW   = 8;

  // Glyph rows, bit x lit for glyph column x.
  localparam logic [4:0] GLYPH_ROWS [10][8] = '{
    '{5'h0E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h0E, 5'h00},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h14, 5'h0C, 5'h04, 5'h00},
    '{5'h1F, 5'h08, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E, 5'h00},
    '{5'h02, 5'h02, 5'h1F, 5'h12, 5'h0A, 5'h06, 5'h02, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h11, 5'h0E, 5'h00},
    '{5'h04, 5'h04, 5'h04, 5'h04, 5'h02, 5'h01, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0E, 5'h00}
  };

  // Logo masks, bit x = logo column x.
  localparam logic [7:0] LOGO_RED [8] = '{
    8'h00, 8'h7E, 8'hEF, 8'hE7, 8'hEF, 8'h7E, 8'h00, 8'h00
  };
  localparam logic [7:0] LOGO_WHITE [8] = '{
    8'h00, 8'h00, 8'h10, 8'h18, 8'h10, 8'h00, 8'h00, 8'h00
  };

  // Pixel beat after the input register.
  typedef struct packed {
    logic [ColW-1:0]   column;
    logic [RowW-1:0]   row;
    logic [ShiftW-1:0] shift;
    logic [CountW-1:0] count;
  } pix_t;

  // Beat after the split stage: decimal quotients plus pixel geometry.
  typedef struct packed {
    logic [4:0]        q1000;
    logic [7:0]        q100;
    logic [10:0]       q10;
    logic [CountW-1:0] count;
    logic [RowW-1:0]   row;
    logic [IdxW-1:0]   led_index;
    logic              content;
    logic              logo;
    logic [1:0]        slot;
    logic [2:0]        gx;
  } split_t;

  // Result beat.
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [IdxW-1:0]  led_index;
  } res_t;

  function automatic logic [4:0] glyph_row(input logic [3:0] digit,
                                           input logic [RowW-1:0] row);
    logic [4:0] bits;
    bits = 5'h00;
    if (digit <= 4'd9) begin
      bits = GLYPH_ROWS[digit][row];
    end
    return bits;
  endfunction

endpackage

[src/lmcr_split.sv]
// Split stage: decimal quotients by reciprocal multiply, content column, strip index.
module lmcr_split #(
  parameter int COLUMNS = lmcr_pkg::ColumnsDefault
) (
  input  logic            clk,
  input  logic            en,
  input  lmcr_pkg::pix_t  pix,
  output lmcr_pkg::split_t split_r
);
  import lmcr_pkg::*;

  localparam int RawW  = $clog2(8 * COLUMNS) + 1;
  localparam int WideW = (RawW > IdxW) ? RawW : IdxW;

  // v/10, v/100, v/1000 exact for v < 2**14
  localparam logic [15:0] Recip10   = 16'd52429;
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam logic [14:0] Recip1000 = 15'd16778;

  logic [29:0]      p10;
  logic [26:0]      p100;
  logic [28:0]      p1000;
  logic [7:0]       local_col;
  logic [4:0]       lc;
  logic [1:0]       slot;
  logic [4:0]       slot_base;
  logic [4:0]       dx;
  logic             on_matrix;
  logic [WideW-1:0] row_w;
  logic [WideW-1:0] idx_w;
  split_t           split_nxt;

  always_comb begin
    p10   = 30'(pix.count) * 30'(Recip10);
    p100  = 27'(pix.count) * 27'(Recip100);
    p1000 = 29'(pix.count) * 29'(Recip1000);

    on_matrix = WideW'(pix.column) < WideW'(COLUMNS);
    row_w     = WideW'(pix.row);
    if (!on_matrix) begin
      idx_w = '0;
    end else if (!pix.row[0]) begin
      idx_w = row_w * WideW'(COLUMNS) + WideW'(pix.column);
    end else begin
      idx_w = (row_w + WideW'(1)) * WideW'(COLUMNS) - WideW'(pix.column) - WideW'(1);
    end

    local_col = {3'b000, pix.column} - {{2{pix.shift[ShiftW-1]}}, pix.shift};
    lc        = local_col[4:0];

    if (lc >= 5'd18) begin
      slot = 2'd3;
    end else if (lc >= 5'd12) begin
      slot = 2'd2;
    end else if (lc >= 5'd6) begin
      slot = 2'd1;
    end else begin
      slot = 2'd0;
    end
    slot_base = {1'b0, slot, 2'b00} + {2'b00, slot, 1'b0};
    dx        = lc - slot_base;

    split_nxt.q1000     = p1000[28:24];
    split_nxt.q100      = p100[26:19];
    split_nxt.q10       = p10[29:19];
    split_nxt.count     = pix.count;
    split_nxt.row       = pix.row;
    split_nxt.led_index = idx_w[IdxW-1:0];
    split_nxt.content   = on_matrix && (local_col[7:5] == 3'b000);
    split_nxt.logo      = (lc[4:3] == 2'b11);
    split_nxt.slot      = slot;
    split_nxt.gx        = split_nxt.logo ? lc[2:0] : dx[2:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      split_r <= split_nxt;
    end
  end

endmodule

[src/lmcr_shade.sv]
// Shade stage: digit extraction, zero blanking, glyph and logo lookup, colour.
module lmcr_shade (
  input  logic                          clk,
  input  logic                          en,
  input  logic [lmcr_pkg::ChanW-1:0]    brightness,
  input  lmcr_pkg::split_t              split,
  output lmcr_pkg::res_t                res_r
);
  import lmcr_pkg::*;

  typedef enum logic [1:0] {
    COL_BLACK,
    COL_RED,
    COL_WHITE
  } colour_t;

  logic [7:0]  d2_w;
  logic [10:0] d1_w;
  logic [13:0] d0_w;
  logic [4:0]  d3;
  logic [3:0]  d2;
  logic [3:0]  d1;
  logic [3:0]  d0;
  logic        lead3;
  logic        lead2;
  logic        lead1;
  logic        lead0;
  logic [3:0]  dsel;
  logic        show;
  logic [7:0]  gbits;
  colour_t     colour;
  res_t        res_nxt;

  always_comb begin
    d3   = split.q1000;
    d2_w = split.q100 - {split.q1000[4:0], 3'b000} - {2'b00, split.q1000, 1'b0};
    d1_w = split.q10 - {split.q100, 3'b000} - {2'b00, split.q100, 1'b0};
    d0_w = split.count - {split.q10, 3'b000} - {2'b00, split.q10, 1'b0};
    d2   = d2_w[3:0];
    d1   = d1_w[3:0];
    d0   = d0_w[3:0];

    // Blank leading zeros; an oversized thousands digit still enables the rest.
    lead3 = (d3 != 5'd0);
    lead2 = lead3 || (d2 != 4'd0);
    lead1 = lead2 || (d1 != 4'd0);
    lead0 = lead1 || (d0 != 4'd0);

    case (split.slot)
      2'd3: begin
        dsel = d3[3:0];
        show = lead3 && (d3 < 5'd10);
      end
      2'd2: begin
        dsel = d2;
        show = lead2;
      end
      2'd1: begin
        dsel = d1;
        show = lead1;
      end
      default: begin
        dsel = d0;
        show = lead0;
      end
    endcase

    gbits  = {3'b000, glyph_row(dsel, split.row)};
    colour = COL_BLACK;
    if (split.content) begin
      if (split.logo) begin
        if (LOGO_WHITE[split.row][split.gx]) begin
          colour = COL_WHITE;
        end else if (LOGO_RED[split.row][split.gx]) begin
          colour = COL_RED;
        end
      end else if (show && (split.gx < 3'd5) && gbits[split.gx]) begin
        colour = COL_WHITE;
      end
    end

    res_nxt.led_index = split.led_index;
    res_nxt.red       = (colour != COL_BLACK) ? brightness : '0;
    res_nxt.green     = (colour == COL_WHITE) ? brightness : '0;
    res_nxt.blue      = (colour == COL_WHITE) ? brightness : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

[src/led_matrix_counter_renderer_top.sv]
// Top level of the LED matrix counter renderer: handshake, brightness register, pipeline.
//
// Renders one pixel of an 8-row matrix showing a four-digit decimal counter beside a
// two-colour logo, plus the pixel's serpentine strip index. Each input beat carries a
// column, a row, a scroll offset and the counter value; one result beat follows per
// input beat. The pipeline has three register stages (input, decimal split, shade), and
// a result beat is offered after passing through all three in that order, and a new pixel
// is accepted every cycle as long as the result side keeps taking beats.
// Ready falls only when all three stages hold beats and the output is stalled. Write
// brightness while no pixels are in flight; it takes effect for pixels accepted
// afterwards.
module led_matrix_counter_renderer_top #(
  parameter int COLUMNS = lmcr_pkg::ColumnsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [4:0] pixel_column, [7:5] pixel_row, [13:8] scroll_shift, [27:14] count_value
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] led_index, [15:8] red, [23:16] green, [31:24] blue
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import lmcr_pkg::*;

  logic             v1_r;
  logic             v2_r;
  logic             vo_r;
  logic             v1_nxt;
  logic             v2_nxt;
  logic             vo_nxt;
  logic             ld1;
  logic             ld2;
  logic             ldo;
  logic [ChanW-1:0] bright_r;
  logic [ChanW-1:0] bright_nxt;
  pix_t             pix_r;
  split_t           split;
  res_t             res;

  // Each stage loads when empty or when the stage after it moves on.
  assign ldo       = !vo_r || out_tready;
  assign ld2       = !v2_r || ldo;
  assign ld1       = !v1_r || ld2;
  assign in_tready = ld1;
  assign cfg_ready = 1'b1;

  always_comb begin
    v1_nxt     = ld1 ? in_tvalid : v1_r;
    v2_nxt     = ld2 ? v1_r : v2_r;
    vo_nxt     = ldo ? v2_r : vo_r;
    bright_nxt = cfg_valid ? cfg_data : bright_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      vo_r     <= 1'b0;
      bright_r <= 8'd32;
    end else begin
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      vo_r     <= vo_nxt;
      bright_r <= bright_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      pix_r.column <= in_tdata[4:0];
      pix_r.row    <= in_tdata[7:5];
      pix_r.shift  <= in_tdata[13:8];
      pix_r.count  <= in_tdata[27:14];
    end
  end

  lmcr_split #(
    .COLUMNS (COLUMNS)
  ) u_split (
    .clk     (clk),
    .en      (ld2),
    .pix     (pix_r),
    .split_r (split)
  );

  lmcr_shade u_shade (
    .clk        (clk),
    .en         (ldo),
    .brightness (bright_r),
    .split      (split),
    .res_r      (res)
  );

  assign out_tvalid = vo_r;
  assign out_tdata  = {res.blue, res.green, res.red, res.led_index};

  // Ready may drop only behind a stalled, full pipeline.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && vo_r && !out_tready))
    else $error("input stalled without a full, blocked pipeline");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed");

  // Green and blue are lit together (white only).
  a_green_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:16] == out_tdata[31:24]))
    else $error("green and blue channels differ");

  // An accepted beat is held in the input register on the next edge.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted beat lost at the input register");

endmodule

[tb/sv/lmcr_checker.sv]
`timescale 1ns / 100ps
// Pixel checker: watches all three channels, predicts each pixel result and compares it.
module lmcr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          pending_results
);
  import lmcr_pkg::*;

  localparam int         FRAME_COLUMNS  = 32;
  localparam logic [7:0] BRIGHT_AT_RST  = 8'd32;
  localparam int         LOGO_FIRST_COL = 24;
  localparam int         CONTENT_COLS   = 32;

  typedef enum logic [1:0] {HUE_BLACK, HUE_RED, HUE_WHITE} hue_t;

  // 5x8 digit font, bit x lit for glyph column x.
  localparam logic [4:0] DIGIT_FONT [10][8] = '{
    '{5'h0E, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h0E, 5'h00},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h14, 5'h0C, 5'h04, 5'h00},
    '{5'h1F, 5'h08, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E, 5'h00},
    '{5'h02, 5'h02, 5'h1F, 5'h12, 5'h0A, 5'h06, 5'h02, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h11, 5'h0E, 5'h00},
    '{5'h04, 5'h04, 5'h04, 5'h04, 5'h02, 5'h01, 5'h1F, 5'h00},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h00},
    '{5'h0E, 5'h11, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0E, 5'h00}
  };
  localparam logic [7:0] EMBLEM_RED [8] = '{
    8'h00, 8'h7E, 8'hEF, 8'hE7, 8'hEF, 8'h7E, 8'h00, 8'h00
  };
  localparam logic [7:0] EMBLEM_WHITE [8] = '{
    8'h00, 8'h00, 8'h10, 8'h18, 8'h10, 8'h00, 8'h00, 8'h00
  };

  logic [7:0] brightness;
  res_t       expected_pixels [$];

  function automatic res_t shade_pixel(input logic [ColW-1:0]          column,
                                       input logic [RowW-1:0]          row,
                                       input logic signed [ShiftW-1:0] shift,
                                       input logic [CountW-1:0]        count,
                                       input logic [7:0]               level);
    int   col_i;
    int   row_i;
    int   sh;
    int   pos;
    int   strip;
    int   slot;
    int   gx;
    int   digit [4];
    bit   shown [4];
    bit   lead;
    hue_t hue;
    res_t r;
    col_i = column;
    row_i = row;
    sh    = shift;
    pos   = col_i - sh;
    hue   = HUE_BLACK;
    // serpentine: odd rows run right to left
    if (row[0] == 1'b0) begin
      strip = row_i * FRAME_COLUMNS + col_i;
    end else begin
      strip = (row_i + 1) * FRAME_COLUMNS - (col_i + 1);
    end
    if (pos >= 0 && pos < CONTENT_COLS) begin
      if (pos >= LOGO_FIRST_COL) begin
        gx = pos - LOGO_FIRST_COL;
        if (EMBLEM_WHITE[row_i][gx]) begin
          hue = HUE_WHITE;
        end else if (EMBLEM_RED[row_i][gx]) begin
          hue = HUE_RED;
        end
      end else begin
        slot     = pos / 6;
        gx       = pos % 6;
        digit[3] = count / 1000;
        digit[2] = (count % 1000) / 100;
        digit[1] = (count % 100) / 10;
        digit[0] = count % 10;
        // thousands of ten or more is blank but still counts as a leading digit
        lead     = digit[3] > 0;
        shown[3] = lead && digit[3] < 10;
        lead     = lead || digit[2] > 0;
        shown[2] = lead;
        lead     = lead || digit[1] > 0;
        shown[1] = lead;
        lead     = lead || digit[0] > 0;
        shown[0] = lead;
        if (gx < 5 && shown[slot]) begin
          if (DIGIT_FONT[digit[slot]][row_i][gx]) begin
            hue = HUE_WHITE;
          end
        end
      end
    end
    r.led_index = strip[7:0];
    r.red       = (hue != HUE_BLACK) ? level : 8'd0;
    r.green     = (hue == HUE_WHITE) ? level : 8'd0;
    r.blue      = (hue == HUE_WHITE) ? level : 8'd0;
    return r;
  endfunction

  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    if (!rst_n) begin
      brightness = BRIGHT_AT_RST;
      expected_pixels.delete();
      mismatches = 0;
      pending_results <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_pixels.push_back(shade_pixel(in_tdata[4:0], in_tdata[7:5], in_tdata[13:8],
                                              in_tdata[27:14], brightness));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_pixels.size() == 0) begin
          $error("result beat with no pixel pending: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_channel("led_index", want.led_index, got.led_index);
          check_channel("red", want.red, got.red);
          check_channel("green", want.green, got.green);
          check_channel("blue", want.blue, got.blue);
        end
      end
      // config lands after the pixel prediction above; writes only happen while idle
      if (cfg_valid && cfg_ready) begin
        brightness = cfg_data;
      end
      pending_results <= expected_pixels.size();
    end
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench top: clock, reset, pixel and brightness stimulus, run verdict.
module tb;
  import lmcr_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_PER_LEVEL = 240;
  localparam int CHUNK            = 40;
  localparam int PIPE_SLACK       = 4;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  bit in_idle  = 1'b1;
  bit out_idle = 1'b1;
  int mismatches;
  int pending_results;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  led_matrix_counter_renderer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  lmcr_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // Abort when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: while out_idle is set, stall a random number of cycles before taking each beat.
  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(13, 0) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Leaves tvalid high after the beat; callers drop it before time passes idle.
  task automatic send_pixel(input logic [4:0] column, input logic [2:0] row,
                            input logic [5:0] shift, input logic [13:0] count);
    int gap;
    gap = in_idle ? $urandom_range(13, 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, count, shift, row, column};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic set_brightness(input logic [7:0] level);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= level;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_pixel();
    logic [5:0]  shift;
    logic [13:0] count;
    // spread counts over every leading-zero regime and the blank-thousands range
    case ($urandom_range(9, 0))
      0:       count = 14'd0;
      1:       count = 14'($urandom_range(9, 1));
      2:       count = 14'($urandom_range(99, 10));
      3:       count = 14'($urandom_range(999, 100));
      4, 5:    count = 14'($urandom_range(9999, 1000));
      6:       count = 14'($urandom_range(16383, 10000));
      default: count = 14'($urandom_range(16383, 0));
    endcase
    if ($urandom_range(99, 0) < 85) begin
      shift = 6'(0 - int'($urandom_range(31, 0)));
    end else begin
      shift = 6'($urandom);
    end
    send_pixel(5'($urandom), 3'($urandom), shift, count);
  endtask

  initial begin : stimulus
    logic [1:0] mode;
    logic [7:0] level;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pixels at reset brightness
    send_pixel(5'd0,  3'd0, 6'd0,       14'd0);     // zero shows nothing
    send_pixel(5'd31, 3'd7, 6'd0,       14'd16383); // last pixel, blank thousands
    send_pixel(5'd27, 3'd3, 6'd0,       14'd1234);  // logo white
    send_pixel(5'd28, 3'd2, 6'd0,       14'd1234);  // logo white
    send_pixel(5'd25, 3'd2, 6'd0,       14'd1234);  // logo red
    send_pixel(5'd1,  3'd0, 6'd0,       14'd1);     // units glyph lit
    send_pixel(5'd7,  3'd0, 6'd0,       14'd8);     // leading zero tens
    send_pixel(5'd7,  3'd0, 6'd0,       14'd18);    // tens shown
    send_pixel(5'd19, 3'd1, 6'd0,       14'd12000); // thousands of twelve blanked
    send_pixel(5'd12, 3'd1, 6'd0,       14'd12000); // inner zero still shown
    send_pixel(5'd5,  3'd0, 6'd0,       14'd8888);  // gap column between digits
    send_pixel(5'd0,  3'd3, 6'(-31),    14'd1234);  // far logo column via shift
    send_pixel(5'd31, 3'd3, 6'(-31),    14'd1234);  // content past the right edge
    send_pixel(5'd31, 3'd4, 6'd31,      14'd4321);  // positive shift, local zero
    send_pixel(5'd0,  3'd5, 6'd31,      14'd4321);  // negative local column
    send_pixel(5'd10, 3'd6, 6'b100000,  14'd4321);  // most negative shift
    send_pixel(5'd18, 3'd6, 6'd0,       14'd9999);  // thousands digit
    send_pixel(5'd0,  3'd6, 6'd0,       14'd16383);
    send_pixel(5'd3,  3'd7, 6'd0,       14'd7);     // empty glyph row
    send_pixel(5'd20, 3'd4, 6'(-4),     14'd1000);  // logo red after shift
    send_pixel(5'd12, 3'd2, 6'(-2),     14'd10);
    drain_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       level = 8'd255;
        1:       level = 8'd0;
        2:       level = 8'($urandom_range(254, 2));
        default: level = 8'd1;
      endcase
      set_brightness(level);
      for (int n = 0; n < RANDOM_PER_LEVEL; n++) begin
        if (n % CHUNK == 0) begin
          mode     = 2'($urandom);
          in_idle  = mode[0];
          out_idle = mode[1];
        end
        // hold input until every pixel in flight has come back
        if (p == 0 && n == RANDOM_PER_LEVEL / 2) begin
          drain_results();
        end
        send_random_pixel();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/lmcr_pkg.sv
src/lmcr_split.sv
src/lmcr_shade.sv
src/led_matrix_counter_renderer_top.sv
tb/sv/lmcr_checker.sv
tb/sv/tb.sv
